/* design/sltt_pkg.sv */
// Shared types and constants for the session table with LRU replacement and TTL aging.
`timescale 1ns / 1ps
`default_nettype none
package sltt_pkg;

  // Request opcodes.
  localparam logic [1:0] OP_LOOKUP  = 2'd0;
  localparam logic [1:0] OP_CREATE  = 2'd1;
  localparam logic [1:0] OP_DESTROY = 2'd2;
  localparam logic [1:0] OP_SWEEP   = 2'd3;

  // Field widths fixed by the interface.
  localparam int ID_W       = 64;
  localparam int STAMP_W    = 32;
  localparam int SLOT_IDX_W = 8;
  localparam int COUNT_W    = 9;

  // Reset value of the idle time to live, in seconds.
  localparam logic [STAMP_W-1:0] IDLE_TTL_RESET = 32'd7200;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  // Write command from the sequencer to the slot store.
  typedef struct packed {
    logic                  id_we;
    logic                  stamp_we;
    logic                  set_valid;
    logic                  clr_valid;
    logic [SLOT_IDX_W-1:0] addr;
    logic [ID_W-1:0]       id;
    logic [STAMP_W-1:0]    stamp;
  } store_wr_t;

endpackage
`default_nettype wire

/* design/sltt_store.sv */
// Slot store: identifier and timestamp memories with per-slot valid bits.
`timescale 1ns / 1ps
`default_nettype none
module sltt_store #(
  parameter int SLOT_COUNT = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire  [sltt_pkg::SLOT_IDX_W-1:0]      rd_addr,
  input  wire  sltt_pkg::store_wr_t            wr,
  output logic [sltt_pkg::ID_W-1:0]            rd_id,
  output logic [sltt_pkg::STAMP_W-1:0]         rd_stamp,
  output logic                                 rd_valid
);

  localparam int IDX_W = $clog2(SLOT_COUNT);

  logic [sltt_pkg::ID_W-1:0]    mem_id    [SLOT_COUNT];
  logic [sltt_pkg::STAMP_W-1:0] mem_stamp [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]        valid;

  logic [IDX_W-1:0] wa;
  logic [IDX_W-1:0] ra;

  assign wa = wr.addr[IDX_W-1:0];
  assign ra = rd_addr[IDX_W-1:0];

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (wr.id_we) begin
      mem_id[wa] <= wr.id;
    end
    if (wr.stamp_we) begin
      mem_stamp[wa] <= wr.stamp;
    end
    rd_id    <= mem_id[ra];
    rd_stamp <= mem_stamp[ra];
  end

  // Valid bits: a slot that is not valid reads as free.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.set_valid) begin
        valid[wa] <= 1'b1;
      end else if (wr.clr_valid) begin
        valid[wa] <= 1'b0;
      end
      rd_valid <= valid[ra];
    end
  end

endmodule
`default_nettype wire

/* design/session_table_lru_ttl_core.sv */
// Top level of the session table with LRU replacement and TTL aging.
// A new item is accepted only while busy is low; busy stays high through the scan, which
// reads one slot a cycle through the single read port of the slot store into one shared
// compare unit, and through the finish state, so items do not overlap.
// Reset clears every slot at once through the valid bits and sets idle_ttl to 7200.
// Results are strobed for one cycle; the receiver cannot stall them.
`timescale 1ns / 1ps
`default_nettype none
module session_table_lru_ttl_core #(
  parameter int SLOT_COUNT = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  opcode,
  input  wire  [63:0] session_id,
  input  wire  [31:0] now_time,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata,
  output logic        done,
  output logic        hit,
  output logic [7:0]  slot_index,
  output logic        evicted,
  output logic [63:0] evicted_id,
  output logic [8:0]  expired_count
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] SLOTS    = CNT_W'(SLOT_COUNT);

  sltt_pkg::state_t state;

  logic [31:0]      idle_ttl;
  logic [1:0]       op;
  logic [63:0]      id;
  logic [31:0]      now;
  logic [31:0]      thr;
  logic [CNT_W-1:0] rd_cnt;
  logic             pv;
  logic [IDX_W-1:0] proc_idx;
  logic             found;
  logic [IDX_W-1:0] pick;
  logic [IDX_W-1:0] oldest;
  logic [31:0]      oldest_stamp;
  logic [63:0]      oldest_id;
  logic [CNT_W-1:0] cnt;

  logic [sltt_pkg::SLOT_IDX_W-1:0] rd_addr;
  sltt_pkg::store_wr_t             wr;
  logic [63:0]                     rd_id;
  logic [31:0]                     rd_stamp;
  logic                            rd_valid;

  logic [63:0] id_eff;
  logic        is_free;
  logic        id_match;
  logic [31:0] cmp_b;
  logic        older;
  logic        accept;
  logic        sweep_free;

  sltt_store #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .rd_id    (rd_id),
    .rd_stamp (rd_stamp),
    .rd_valid (rd_valid)
  );

  assign busy   = (state != sltt_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Shared compare unit: the slot time against the oldest so far or the sweep threshold.
  assign id_eff     = rd_valid ? rd_id : 64'd0;
  assign is_free    = (id_eff == 64'd0);
  assign id_match   = (id != 64'd0) && (id_eff == id);
  assign cmp_b      = (op == sltt_pkg::OP_SWEEP) ? thr : oldest_stamp;
  assign older      = (rd_stamp < cmp_b);
  assign sweep_free = (state == sltt_pkg::ST_SCAN) && pv && (op == sltt_pkg::OP_SWEEP)
                      && !is_free && older;

  // Read address follows the scan counter.
  assign rd_addr = sltt_pkg::SLOT_IDX_W'(rd_cnt[IDX_W-1:0]);

  // Store writes: sweep frees during the scan, the other operations write at the finish.
  always_comb begin
    wr           = '0;
    wr.id        = id;
    wr.stamp     = now;
    wr.addr      = sltt_pkg::SLOT_IDX_W'(pick);
    if (sweep_free) begin
      wr.clr_valid = 1'b1;
      wr.addr      = sltt_pkg::SLOT_IDX_W'(proc_idx);
    end else if (state == sltt_pkg::ST_FINISH) begin
      case (op)
        sltt_pkg::OP_LOOKUP: begin
          wr.stamp_we = found;
        end
        sltt_pkg::OP_CREATE: begin
          wr.id_we     = 1'b1;
          wr.stamp_we  = 1'b1;
          wr.set_valid = 1'b1;
          if (!found) begin
            wr.addr = sltt_pkg::SLOT_IDX_W'(oldest);
          end
        end
        sltt_pkg::OP_DESTROY: begin
          wr.clr_valid = found;
        end
        default: begin
          wr.stamp_we = 1'b0;
        end
      endcase
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ttl <= sltt_pkg::IDLE_TTL_RESET;
    end else if (cfg_we) begin
      idle_ttl <= cfg_wdata;
    end
  end

  // Sequencer control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sltt_pkg::ST_IDLE;
      pv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        sltt_pkg::ST_IDLE: begin
          if (accept) begin
            state <= sltt_pkg::ST_SCAN;
            pv    <= 1'b0;
          end
        end
        sltt_pkg::ST_SCAN: begin
          pv <= (rd_cnt < SLOTS);
          if (pv && (proc_idx == LAST_IDX)) begin
            state <= sltt_pkg::ST_FINISH;
          end
        end
        sltt_pkg::ST_FINISH: begin
          state <= sltt_pkg::ST_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= sltt_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Request capture, scan bookkeeping and result registers.
  always_ff @(posedge clk) begin
    case (state)
      sltt_pkg::ST_IDLE: begin
        if (accept) begin
          op     <= opcode;
          id     <= session_id;
          now    <= now_time;
          thr    <= (now_time > idle_ttl) ? (now_time - idle_ttl) : 32'd0;
          rd_cnt <= '0;
          found  <= 1'b0;
          pick   <= '0;
          cnt    <= '0;
        end
      end
      sltt_pkg::ST_SCAN: begin
        if (rd_cnt < SLOTS) begin
          proc_idx <= rd_cnt[IDX_W-1:0];
          rd_cnt   <= rd_cnt + CNT_W'(1);
        end
        if (pv) begin
          case (op)
            sltt_pkg::OP_CREATE: begin
              if (!found) begin
                if (is_free) begin
                  found <= 1'b1;
                  pick  <= proc_idx;
                end else if ((proc_idx == '0) || older) begin
                  oldest       <= proc_idx;
                  oldest_stamp <= rd_stamp;
                  oldest_id    <= id_eff;
                end
              end
            end
            sltt_pkg::OP_SWEEP: begin
              if (sweep_free) begin
                cnt <= cnt + CNT_W'(1);
              end
            end
            default: begin
              if (!found && id_match) begin
                found <= 1'b1;
                pick  <= proc_idx;
              end
            end
          endcase
        end
      end
      sltt_pkg::ST_FINISH: begin
        hit           <= 1'b0;
        slot_index    <= 8'd0;
        evicted       <= 1'b0;
        evicted_id    <= 64'd0;
        expired_count <= 9'd0;
        case (op)
          sltt_pkg::OP_CREATE: begin
            hit <= 1'b1;
            if (found) begin
              slot_index <= 8'(pick);
            end else begin
              slot_index <= 8'(oldest);
              evicted    <= 1'b1;
              evicted_id <= oldest_id;
            end
          end
          sltt_pkg::OP_SWEEP: begin
            expired_count <= 9'(cnt);
          end
          default: begin
            hit <= found;
            if (found) begin
              slot_index <= 8'(pick);
            end
          end
        endcase
      end
      default: begin
        found <= 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* dv/session_table_check.sv */
// Checker that mirrors the session table, predicts each result and compares it with the block.
`timescale 1ns / 1ps
module session_table_check #(
  parameter int SLOT_COUNT = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire         busy,
  input  wire  [1:0]  opcode,
  input  wire  [63:0] session_id,
  input  wire  [31:0] now_time,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata,
  input  wire         done,
  input  wire         hit,
  input  wire  [7:0]  slot_index,
  input  wire         evicted,
  input  wire  [63:0] evicted_id,
  input  wire  [8:0]  expired_count,
  output int          fail_count,
  output int          outstanding,
  output int          checked_count,
  output int          hit_count,
  output int          evict_count,
  output int          aged_out_count
);

  // One result as the block reports it.
  typedef struct packed {
    logic                            hit;
    logic [sltt_pkg::SLOT_IDX_W-1:0] slot;
    logic                            evicted;
    logic [sltt_pkg::ID_W-1:0]       evicted_id;
    logic [sltt_pkg::COUNT_W-1:0]    freed;
  } table_result_t;

  // Mirror of the slot store and the idle time to live.
  logic [sltt_pkg::ID_W-1:0]    slot_id    [SLOT_COUNT];
  logic [sltt_pkg::STAMP_W-1:0] slot_stamp [SLOT_COUNT];
  logic [sltt_pkg::STAMP_W-1:0] idle_ttl_copy;

  table_result_t expected_results[$];
  int errs, n_checked, n_hits, n_evicts, n_aged;

  initial begin
    errs      = 0;
    n_checked = 0;
    n_hits    = 0;
    n_evicts  = 0;
    n_aged    = 0;
  end

  // Applies one request to the mirror and returns the result it should give.
  function automatic table_result_t apply_request(input logic [1:0] op,
                                                  input logic [sltt_pkg::ID_W-1:0] id,
                                                  input logic [sltt_pkg::STAMP_W-1:0] t);
    table_result_t res;
    int pick;
    int oldest;
    logic [sltt_pkg::STAMP_W-1:0] thr;
    res    = '0;
    pick   = -1;
    oldest = 0;
    case (op)
      sltt_pkg::OP_LOOKUP, sltt_pkg::OP_DESTROY: begin
        // Identifier zero never matches; duplicates resolve to the lowest slot.
        if (id != '0) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (pick < 0 && slot_id[i] == id) pick = i;
          end
        end
        if (pick >= 0) begin
          res.hit  = 1'b1;
          res.slot = 8'(pick);
          if (op == sltt_pkg::OP_LOOKUP) begin
            slot_stamp[pick] = t;
          end else begin
            slot_id[pick]    = '0;
            slot_stamp[pick] = '0;
          end
        end
      end
      sltt_pkg::OP_CREATE: begin
        // First free slot wins; otherwise the strictly oldest, lowest first.
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (pick < 0) begin
            if (slot_id[i] == '0) pick = i;
            else if (slot_stamp[i] < slot_stamp[oldest]) oldest = i;
          end
        end
        if (pick < 0) begin
          pick           = oldest;
          res.evicted    = 1'b1;
          res.evicted_id = slot_id[pick];
        end
        slot_id[pick]    = id;
        slot_stamp[pick] = t;
        res.hit          = 1'b1;
        res.slot         = 8'(pick);
      end
      sltt_pkg::OP_SWEEP: begin
        // The threshold saturates at zero when the time to live exceeds the time.
        thr = (t > idle_ttl_copy) ? t - idle_ttl_copy : '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_id[i] != '0 && slot_stamp[i] < thr) begin
            slot_id[i]    = '0;
            slot_stamp[i] = '0;
            res.freed     = res.freed + 9'd1;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
    return res;
  endfunction

  // Compare each strobed result with the oldest prediction, then predict new items.
  always @(posedge clk) begin
    table_result_t exp_res;
    table_result_t new_res;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_id[i]    = '0;
        slot_stamp[i] = '0;
      end
      idle_ttl_copy = sltt_pkg::IDLE_TTL_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we) idle_ttl_copy = cfg_wdata;
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result strobed with no item outstanding");
          errs++;
        end else begin
          exp_res = expected_results.pop_front();
          n_checked++;
          if (exp_res.hit) n_hits++;
          if (exp_res.evicted) n_evicts++;
          n_aged += exp_res.freed;
          if (hit !== exp_res.hit) begin
            $error("hit: expected %0d, got %0d", exp_res.hit, hit);
            errs++;
          end
          if (slot_index !== exp_res.slot) begin
            $error("slot_index: expected %0d, got %0d", exp_res.slot, slot_index);
            errs++;
          end
          if (evicted !== exp_res.evicted) begin
            $error("evicted: expected %0d, got %0d", exp_res.evicted, evicted);
            errs++;
          end
          if (evicted_id !== exp_res.evicted_id) begin
            $error("evicted_id: expected %h, got %h", exp_res.evicted_id, evicted_id);
            errs++;
          end
          if (expired_count !== exp_res.freed) begin
            $error("expired_count: expected %0d, got %0d", exp_res.freed, expired_count);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        new_res          = apply_request(opcode, session_id, now_time);
        expected_results = {expected_results, new_res};
      end
    end
    fail_count     <= errs;
    outstanding    <= expected_results.size();
    checked_count  <= n_checked;
    hit_count      <= n_hits;
    evict_count    <= n_evicts;
    aged_out_count <= n_aged;
  end

endmodule

/* dv/session_table_lru_ttl_core_tb.sv */
// Testbench top for the session table: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps
module session_table_lru_ttl_core_tb;

  localparam int SLOT_COUNT  = 16;
  localparam int LATENCY     = SLOT_COUNT + 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 130;
  localparam int POOL_SIZE   = 20;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        start      = 1'b0;
  logic [1:0]  opcode     = sltt_pkg::OP_LOOKUP;
  logic [63:0] session_id = '0;
  logic [31:0] now_time   = '0;
  logic        cfg_we     = 1'b0;
  logic [31:0] cfg_wdata  = '0;

  wire         busy;
  wire         done;
  wire         hit;
  wire  [7:0]  slot_index;
  wire         evicted;
  wire  [63:0] evicted_id;
  wire  [8:0]  expired_count;

  int fail_count, outstanding, checked_count, hit_count, evict_count, aged_out_count;
  int cycles = 0;
  bit burst  = 1'b0;

  session_table_lru_ttl_core #(.SLOT_COUNT(SLOT_COUNT)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .session_id(session_id), .now_time(now_time),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .hit(hit), .slot_index(slot_index), .evicted(evicted),
    .evicted_id(evicted_id), .expired_count(expired_count)
  );

  session_table_check #(.SLOT_COUNT(SLOT_COUNT)) u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .session_id(session_id), .now_time(now_time),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .hit(hit), .slot_index(slot_index), .evicted(evicted),
    .evicted_id(evicted_id), .expired_count(expired_count),
    .fail_count(fail_count), .outstanding(outstanding), .checked_count(checked_count),
    .hit_count(hit_count), .evict_count(evict_count), .aged_out_count(aged_out_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run if the traffic never drains.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Presents one item and holds it until accepted, then idles for a random while.
  // With a zero gap the next item follows straight on without start dropping.
  task automatic send_request(input logic [1:0] op, input logic [63:0] id,
                              input logic [31:0] t);
    int gap;
    start      <= 1'b1;
    opcode     <= op;
    session_id <= id;
    now_time   <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = burst ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 9) == 0) burst = !burst;
    if (gap > 0) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat (gap - 1) @(posedge clk);
    end
  endtask

  // Writes the time to live once the table has gone quiet.
  task automatic write_idle_ttl(input logic [31:0] value);
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [31:0] ttl_plan [5];
    logic [63:0] id_pool [POOL_SIZE];
    logic [63:0] id;
    logic [31:0] clock_now;
    logic [1:0]  op;
    int          step;
    int          r;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, under the reset time to live.
    // Identifier zero never matches on lookup or destroy.
    send_request(sltt_pkg::OP_LOOKUP, '0, 32'd0);
    send_request(sltt_pkg::OP_DESTROY, '0, 32'd0);
    send_request(sltt_pkg::OP_CREATE, '1, 32'd100);
    // A create of zero is stored but leaves the slot free for the next create.
    send_request(sltt_pkg::OP_CREATE, '0, 32'd100);
    send_request(sltt_pkg::OP_CREATE, 64'h0123_4567_89AB_CDEF, 32'd50);
    // A duplicate create stores a second copy; lookups then find the lower one.
    send_request(sltt_pkg::OP_CREATE, 64'h0123_4567_89AB_CDEF, 32'd60);
    send_request(sltt_pkg::OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'd70);
    send_request(sltt_pkg::OP_DESTROY, 64'h0123_4567_89AB_CDEF, 32'd75);
    send_request(sltt_pkg::OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'd80);
    // Fill the table with tied stamps so that the eviction must pick the lowest oldest slot.
    for (int i = 0; i < 14; i++) begin
      send_request(sltt_pkg::OP_CREATE, {$urandom, $urandom},
                   (i % 3 == 0) ? 32'd20 : 32'd30 + i);
    end
    send_request(sltt_pkg::OP_CREATE, 64'hFEDC_BA98_7654_3210, 32'hFFFF_FFFF);
    // Sweep frees the stale slots; a sweep at time zero saturates and frees nothing.
    send_request(sltt_pkg::OP_SWEEP, '1, 32'd7225);
    send_request(sltt_pkg::OP_SWEEP, '0, 32'd0);
    start <= 1'b0;

    // Random phases, each under its own time to live.
    ttl_plan[0] = 32'd30;
    ttl_plan[1] = 32'd0;
    ttl_plan[2] = 32'hFFFF_FFFF;
    ttl_plan[3] = 32'd500;
    ttl_plan[4] = $urandom;
    clock_now   = 32'd1000;
    foreach (ttl_plan[p]) begin
      write_idle_ttl(ttl_plan[p]);
      step = (ttl_plan[p] >= 1 && ttl_plan[p] <= 3000) ? ttl_plan[p] / 3 + 1 : 25;
      // A pool a little larger than the table keeps hits and evictions both common.
      foreach (id_pool[k]) id_pool[k] = {$urandom, $urandom};
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r  = $urandom_range(0, 99);
        op = (r < 35) ? sltt_pkg::OP_LOOKUP :
             (r < 65) ? sltt_pkg::OP_CREATE :
             (r < 80) ? sltt_pkg::OP_DESTROY : sltt_pkg::OP_SWEEP;
        r  = $urandom_range(0, 99);
        if (r < 85) id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 92) id = '0;
        else id = {$urandom, $urandom};
        // Time mostly creeps forward, with occasional jumps and extremes.
        r = $urandom_range(0, 99);
        if (r < 3) clock_now = $urandom;
        else if (r < 4) clock_now = '0;
        else if (r < 5) clock_now = '1;
        else clock_now = clock_now + $urandom_range(0, step);
        send_request(op, id, clock_now);
      end
      start <= 1'b0;
    end

    // Drain the remaining results and allow for any stray strobe.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Checked %0d results: %0d hits, %0d evictions, %0d sessions aged out.",
             checked_count, hit_count, evict_count, aged_out_count);
    $display("Time to live swept through 7200, 30, 0, all ones, 500 and one random value.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
